>>> rtl/assert_macros.svh
// Assertion helpers shared by the key long-press event generator RTL.
// Each macro expands to one labeled concurrent assertion, disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define KLP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("klp assertion failed");

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define KLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("klp assertion failed");

`endif

>>> rtl/klp_pkg.sv
// Package for the key long-press event generator: widths, codes and shared types.
// No dependencies; used by the interfaces and every RTL module.
`default_nettype none

package klp_pkg;

    // Field widths
    localparam int KEY_W      = 16;
    localparam int CODE_W     = 3;
    localparam int SEQ_W      = 16;
    localparam int TICK_W     = 32;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Number of key slots by default
    localparam int KEY_SLOTS_DEF = 6;

    // Register reset values
    localparam logic [TICK_W-1:0] LONG_TICKS_RST = TICK_W'(1000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SLOT0  = CFG_IDX_W'(2);

    // Input item commands
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result event codes
    typedef enum logic [CODE_W-1:0] {
        EV_PRESS                  = 3'd0,
        EV_RELEASE                = 3'd1,
        EV_PRESS_AND_RELEASE      = 3'd2,
        EV_LONG_PRESS             = 3'd3,
        EV_LONG_PRESS_AND_RELEASE = 3'd4
    } t_event_code;

    // One result item
    typedef struct packed {
        logic [KEY_W-1:0] event_key;
        t_event_code      event_code;
        logic [SEQ_W-1:0] sequence_res;
        logic             last;
    } t_result;

    // Results of one processed item, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

>>> rtl/klp_if.sv
// Valid/ready channel interfaces for the key long-press event generator.
// Depends on klp_pkg for field widths.
`default_nettype none

// Input item channel: key change or timer tick
interface klp_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [klp_pkg::KEY_W-1:0] key_id;
    logic                      key_down;

    modport source (output valid, command, key_id, key_down, input ready);
    modport sink   (input valid, command, key_id, key_down, output ready);
endinterface

// Result item channel
interface klp_out_if;
    logic                       valid;
    logic                       ready;
    logic [klp_pkg::KEY_W-1:0]  event_key;
    logic [klp_pkg::CODE_W-1:0] event_code;
    logic [klp_pkg::SEQ_W-1:0]  sequence_res;
    logic                       last;

    modport source (output valid, event_key, event_code, sequence_res, last, input ready);
    modport sink   (input valid, event_key, event_code, sequence_res, last, output ready);
endinterface

// Configuration write channel
interface klp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [klp_pkg::CFG_IDX_W-1:0]  index;
    logic [klp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/klp_cfg.sv
// Configuration registers and key slot matching.
// Depends on klp_pkg and klp_cfg_if.
`default_nettype none

module klp_cfg #(
    parameter int KEY_SLOTS = klp_pkg::KEY_SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    klp_cfg_if.sink                            i_cfg,
    input  wire logic [klp_pkg::KEY_W-1:0]     i_key,
    output logic                               o_match,
    output logic      [klp_pkg::TICK_W-1:0]    o_long_press_ticks
);

    logic [klp_pkg::TICK_W-1:0] r_long_ticks;
    logic [klp_pkg::CNT_W-1:0]  r_slots_used;
    logic [klp_pkg::KEY_W-1:0]  r_slot [KEY_SLOTS];
    logic [klp_pkg::CNT_W-1:0]  eff_count;
    logic                       wr;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid;

    // Register file; unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= klp_pkg::LONG_TICKS_RST;
            r_slots_used <= '0;
            for (int s = 0; s < KEY_SLOTS; s++) begin
                r_slot[s] <= '0;
            end
        end else if (wr) begin
            if (i_cfg.index == klp_pkg::REG_LONG_TICKS) begin
                r_long_ticks <= i_cfg.data[klp_pkg::TICK_W-1:0];
            end
            if (i_cfg.index == klp_pkg::REG_KEY_COUNT) begin
                r_slots_used <= i_cfg.data[klp_pkg::CNT_W-1:0];
            end
            for (int s = 0; s < KEY_SLOTS; s++) begin
                if (i_cfg.index == klp_pkg::CFG_IDX_W'(int'(klp_pkg::REG_KEY_SLOT0) + s)) begin
                    r_slot[s] <= i_cfg.data[klp_pkg::KEY_W-1:0];
                end
            end
        end
    end

    // Count above the slot total uses every slot
    assign eff_count = (r_slots_used > klp_pkg::CNT_W'(KEY_SLOTS))
                     ? klp_pkg::CNT_W'(KEY_SLOTS) : r_slots_used;

    // Compare against all enabled slots in parallel
    always_comb begin
        o_match = 1'b0;
        for (int s = 0; s < KEY_SLOTS; s++) begin
            if ((klp_pkg::CNT_W'(s) < eff_count) && (r_slot[s] == i_key)) begin
                o_match = 1'b1;
            end
        end
    end

    assign o_long_press_ticks = r_long_ticks;

endmodule

`default_nettype wire

>>> rtl/klp_core.sv
// Input register and press/release/long-press state update.
// Depends on klp_pkg, klp_in_if and assert_macros.svh.
`default_nettype none

module klp_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    klp_in_if.sink                             i_item,
    input  wire logic                          i_match,
    input  wire logic [klp_pkg::TICK_W-1:0]    i_long_press_ticks,
    input  wire logic                          i_room,
    output logic      [klp_pkg::KEY_W-1:0]     o_key,
    output klp_pkg::t_push                     o_push
);

    // Input register
    logic                       r_in_valid;
    logic                       r_command;
    logic [klp_pkg::KEY_W-1:0]  r_key_id;
    logic                       r_key_down;

    // Detector state
    logic                       r_is_down,       n_is_down;
    logic                       r_long_held,     n_long_held;
    logic [klp_pkg::KEY_W-1:0]  r_last_key,      n_last_key;
    logic [klp_pkg::SEQ_W-1:0]  r_seq,           n_seq;
    logic                       r_timer_running, n_timer_running;
    logic [klp_pkg::TICK_W-1:0] r_timer_rem,     n_timer_rem;

    logic proc;
    logic accept;

    // Held item is processed once the queue can take two results
    assign proc          = r_in_valid && i_room;
    assign i_item.ready  = !r_in_valid || proc;
    assign accept        = i_item.valid && i_item.ready;
    assign o_key         = r_key_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command  <= i_item.command;
            r_key_id   <= i_item.key_id;
            r_key_down <= i_item.key_down;
        end
    end

    // Next state and results for the held item
    always_comb begin
        n_is_down       = r_is_down;
        n_long_held     = r_long_held;
        n_last_key      = r_last_key;
        n_timer_running = r_timer_running;
        n_timer_rem     = r_timer_rem;

        o_push.count             = 2'd0;
        o_push.res0.event_key    = r_key_id;
        o_push.res0.event_code   = klp_pkg::EV_PRESS;
        o_push.res0.sequence_res = r_seq;
        o_push.res0.last         = 1'b1;
        o_push.res1.event_key    = r_key_id;
        o_push.res1.event_code   = r_long_held ? klp_pkg::EV_LONG_PRESS_AND_RELEASE
                                               : klp_pkg::EV_PRESS_AND_RELEASE;
        o_push.res1.sequence_res = r_seq + klp_pkg::SEQ_W'(1);
        o_push.res1.last         = 1'b1;

        if (proc) begin
            if (r_command == klp_pkg::CMD_TICK) begin
                // One-shot timer; zero ticks acts as one
                if (r_timer_running) begin
                    if (r_timer_rem <= klp_pkg::TICK_W'(1)) begin
                        n_timer_running        = 1'b0;
                        n_timer_rem            = '0;
                        n_long_held            = 1'b1;
                        o_push.count           = 2'd1;
                        o_push.res0.event_key  = r_last_key;
                        o_push.res0.event_code = klp_pkg::EV_LONG_PRESS;
                    end else begin
                        n_timer_rem = r_timer_rem - klp_pkg::TICK_W'(1);
                    end
                end
            end else if (i_match) begin
                n_last_key = r_key_id;
                if (r_key_down && !r_is_down) begin
                    // Press edge
                    n_is_down              = 1'b1;
                    n_timer_running        = 1'b1;
                    n_timer_rem            = i_long_press_ticks;
                    o_push.count           = 2'd1;
                    o_push.res0.event_code = klp_pkg::EV_PRESS;
                end else if (!r_key_down && r_is_down) begin
                    // Release edge: two results
                    n_is_down              = 1'b0;
                    n_long_held            = 1'b0;
                    n_timer_running        = 1'b0;
                    n_timer_rem            = '0;
                    o_push.count           = 2'd2;
                    o_push.res0.event_code = klp_pkg::EV_RELEASE;
                    o_push.res0.last       = 1'b0;
                end
            end
        end

        n_seq = r_seq + klp_pkg::SEQ_W'(o_push.count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_down       <= 1'b0;
            r_long_held     <= 1'b0;
            r_last_key      <= '0;
            r_seq           <= '0;
            r_timer_running <= 1'b0;
            r_timer_rem     <= '0;
        end else begin
            r_is_down       <= n_is_down;
            r_long_held     <= n_long_held;
            r_last_key      <= n_last_key;
            r_seq           <= n_seq;
            r_timer_running <= n_timer_running;
            r_timer_rem     <= n_timer_rem;
        end
    end

    // Long hold and a running timer only exist while a key is down
    `include "assert_macros.svh"
    `KLP_ASSERT_NOW(a_long_needs_down, i_clk, i_rst_n, r_long_held, r_is_down)
    `KLP_ASSERT_NOW(a_timer_needs_down, i_clk, i_rst_n, r_timer_running, r_is_down)
    `KLP_ASSERT_NEXT(a_release_clears, i_clk, i_rst_n, o_push.count == 2'd2, !r_is_down && !r_long_held)

endmodule

`default_nettype wire

>>> rtl/klp_outq.sv
// Two-entry result queue that decouples processing from the result channel.
// Depends on klp_pkg, klp_out_if and assert_macros.svh.
`default_nettype none

module klp_outq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire klp_pkg::t_push  i_push,
    output logic                 o_room,
    klp_out_if.source            o_result
);

    klp_pkg::t_result r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       pop;
    logic [1:0] after_pop;

    assign pop       = o_result.valid && o_result.ready;
    assign after_pop = r_count - {1'b0, pop};
    // Room for a two-result item once this cycle's pop is counted
    assign o_room    = (after_pop == 2'd0);
    assign n_count   = after_pop + i_push.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_wr_ptr <= r_wr_ptr ^ i_push.count[0];
            r_rd_ptr <= r_rd_ptr ^ pop;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_q[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_q[!r_wr_ptr] <= i_push.res1;
        end
    end

    // Head of queue drives the channel
    assign o_result.valid        = (r_count != 2'd0);
    assign o_result.event_key    = r_q[r_rd_ptr].event_key;
    assign o_result.event_code   = r_q[r_rd_ptr].event_code;
    assign o_result.sequence_res = r_q[r_rd_ptr].sequence_res;
    assign o_result.last         = r_q[r_rd_ptr].last;

    `include "assert_macros.svh"
    `KLP_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `KLP_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, i_push.count != 2'd0, o_room)

endmodule

`default_nettype wire

>>> rtl/key_long_press_event_generator.sv
// An accepted item is held in the input register until the result queue has room, is
// then processed into the queue, and its first result is offered from the queue head.
// Throughput: one item per cycle while items give at most one result and each result
// is taken at once; a release gives two, and the next item waits until both are taken.
// Reset (synchronous, active low) clears state, sequence count, queue and registers.
`default_nettype none

module key_long_press_event_generator #(
    parameter int KEY_SLOTS = klp_pkg::KEY_SLOTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    klp_in_if.sink     i_item,
    klp_cfg_if.sink    i_cfg,
    klp_out_if.source  o_result
);

    logic                        match;
    logic [klp_pkg::TICK_W-1:0]  long_press_ticks;
    logic [klp_pkg::KEY_W-1:0]   held_key;
    logic                        room;
    klp_pkg::t_push              push;

    // Registers and slot match
    klp_cfg #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (i_cfg),
        .i_key              (held_key),
        .o_match            (match),
        .o_long_press_ticks (long_press_ticks)
    );

    // Detector state machine
    klp_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item             (i_item),
        .i_match            (match),
        .i_long_press_ticks (long_press_ticks),
        .i_room             (room),
        .o_key              (held_key),
        .o_push             (push)
    );

    // Result buffering
    klp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> verif/key_long_press_event_generator_tb.sv
// Self-checking testbench for key_long_press_event_generator: key changes and ticks in,
// press / release / long-press events out, checked against a behavioral predictor.
// Depends on klp_pkg and the channel interfaces in klp_if.sv.
`default_nettype none

module key_long_press_event_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import klp_pkg::*;

    localparam int STALL_LIMIT = 5000;   // cycles with no accepted item before giving up
    localparam int SETTLE_CYCLES = 8;    // pipeline latency plus margin
    localparam int PHASE_ITEMS = 230;

    // Predicts the event stream and checks what the block emits
    class key_event_scoreboard;
        logic [TICK_W-1:0] long_ticks;
        logic [CNT_W-1:0]  slots_used;
        logic [KEY_W-1:0]  key_slot [KEY_SLOTS_DEF];
        bit                held_down;
        bit                long_held;
        bit                timer_on;
        logic [TICK_W-1:0] ticks_left;
        logic [KEY_W-1:0]  last_key;
        logic [SEQ_W-1:0]  seq_count;
        t_result           pending_events [$];
        int unsigned       fail_count;

        function new();
            long_ticks  = LONG_TICKS_RST;
            slots_used  = '0;
            foreach (key_slot[i]) key_slot[i] = '0;
            held_down   = 1'b0;
            long_held   = 1'b0;
            timer_on    = 1'b0;
            ticks_left  = '0;
            last_key    = '0;
            seq_count   = '0;
            fail_count  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_LONG_TICKS) begin
                long_ticks = data[TICK_W-1:0];
            end else if (idx == REG_KEY_COUNT) begin
                slots_used = data[CNT_W-1:0];
            end else if (idx >= REG_KEY_SLOT0) begin
                key_slot[idx - REG_KEY_SLOT0] = data[KEY_W-1:0];
            end
        endfunction

        function bit slot_hit(logic [KEY_W-1:0] key);
            int lim;
            lim = (slots_used > KEY_SLOTS_DEF) ? KEY_SLOTS_DEF : slots_used;
            for (int i = 0; i < lim; i++) begin
                if (key_slot[i] == key) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push_event(logic [KEY_W-1:0] key, t_event_code code);
            t_result ev;
            ev.event_key    = key;
            ev.event_code   = code;
            ev.sequence_res = seq_count;
            ev.last         = 1'b0;
            pending_events.push_back(ev);
            seq_count++;
        endfunction

        // Accepted input item: update state, queue the events it causes
        function void note_item(logic cmd, logic [KEY_W-1:0] key, logic down);
            int n_before;
            bit was_long;
            n_before = pending_events.size();
            if (cmd == CMD_TICK) begin
                if (timer_on) begin
                    if (ticks_left <= 1) begin
                        timer_on   = 1'b0;
                        ticks_left = '0;
                        long_held  = 1'b1;
                        push_event(last_key, EV_LONG_PRESS);
                    end else begin
                        ticks_left--;
                    end
                end
            end else if (slot_hit(key)) begin
                last_key = key;
                if (down && !held_down) begin
                    held_down  = 1'b1;
                    timer_on   = 1'b1;
                    ticks_left = long_ticks;
                    push_event(key, EV_PRESS);
                end else if (!down && held_down) begin
                    was_long   = long_held;
                    held_down  = 1'b0;
                    long_held  = 1'b0;
                    timer_on   = 1'b0;
                    ticks_left = '0;
                    push_event(key, EV_RELEASE);
                    push_event(key, was_long ? EV_LONG_PRESS_AND_RELEASE : EV_PRESS_AND_RELEASE);
                end
            end
            if (pending_events.size() > n_before)
                pending_events[pending_events.size()-1].last = 1'b1;
        endfunction

        // Accepted result item: compare with the oldest expected event
        function void check_result(t_result got);
            t_result want;
            if (pending_events.size() == 0) begin
                $error("unexpected result: event_key %h event_code %0d sequence_res %0d",
                       got.event_key, got.event_code, got.sequence_res);
                fail_count++;
                return;
            end
            want = pending_events.pop_front();
            if (got.event_key !== want.event_key) begin
                $error("event_key: expected %h, got %h", want.event_key, got.event_key);
                fail_count++;
            end
            if (got.event_code !== want.event_code) begin
                $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
                fail_count++;
            end
            if (got.sequence_res !== want.sequence_res) begin
                $error("sequence_res: expected %0d, got %0d", want.sequence_res,
                       got.sequence_res);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                fail_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    klp_in_if  item_ch ();
    klp_cfg_if cfg_ch ();
    klp_out_if res_ch ();

    key_long_press_event_generator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    key_event_scoreboard sb = new();

    bit               send_idle_en;
    bit               recv_idle_en;
    int unsigned      quiet_cycles;
    logic [KEY_W-1:0] slot_cfg [KEY_SLOTS_DEF];

    // Clock and reset
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Known input levels from time zero
    initial begin
        i_rst_n          = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.command  = CMD_KEY;
        item_ch.key_id   = '0;
        item_ch.key_down = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_LONG_TICKS;
        cfg_ch.data      = '0;
        res_ch.ready     = 1'b0;
        send_idle_en     = 1'b1;
        recv_idle_en     = 1'b1;
    end

    // Result side backpressure
    always @(negedge i_clk) begin
        res_ch.ready <= !recv_idle_en || ($urandom_range(0, 99) >= 15);
    end

    // Handshake monitor: feeds the predictor and checks results
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (item_ch.valid && item_ch.ready)
                sb.note_item(item_ch.command, item_ch.key_id, item_ch.key_down);
            if (res_ch.valid && res_ch.ready) begin
                got.event_key    = res_ch.event_key;
                got.event_code   = t_event_code'(res_ch.event_code);
                got.sequence_res = res_ch.sequence_res;
                got.last         = res_ch.last;
                sb.check_result(got);
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive one input item; valid stays high on return. Starts and ends at a falling edge.
    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key, input logic down);
        while (send_idle_en && $urandom_range(0, 99) < 15) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.command  <= cmd;
        item_ch.key_id   <= key;
        item_ch.key_down <= down;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    // One register write; valid stays high on return
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // Wait for all expected events, then let in-flight ticks settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.pending_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write every register: tick count, key count and all slots from slot_cfg
    task automatic load_settings(input logic [TICK_W-1:0] ticks, input logic [CNT_W-1:0] count);
        write_reg(REG_LONG_TICKS, CFG_DATA_W'(ticks));
        write_reg(REG_KEY_COUNT, CFG_DATA_W'(count));
        for (int i = 0; i < KEY_SLOTS_DEF; i++)
            write_reg(REG_KEY_SLOT0 + CFG_IDX_W'(i), CFG_DATA_W'(slot_cfg[i]));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [TICK_W-1:0] ticks, input logic [CNT_W-1:0] count);
        int lim;
        logic [KEY_W-1:0] key;
        logic down;
        // Some slots repeat an earlier id to exercise duplicate matches
        for (int i = 0; i < KEY_SLOTS_DEF; i++)
            slot_cfg[i] = (i > 0 && $urandom_range(0, 3) == 0) ? slot_cfg[i-1]
                                                                 : KEY_W'($urandom);
        load_settings(ticks, count);
        lim = (count > KEY_SLOTS_DEF) ? KEY_SLOTS_DEF : count;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            key  = KEY_W'($urandom);
            down = 1'($urandom);
            if ((sb.timer_on && $urandom_range(0, 1) == 1) || $urandom_range(0, 9) == 0) begin
                send_item(CMD_TICK, key, down);
            end else begin
                // Mostly watched keys with a level opposite to the shared state
                if (lim > 0 && $urandom_range(0, 99) >= 15)
                    key = slot_cfg[$urandom_range(0, lim - 1)];
                if ($urandom_range(0, 3) != 0)
                    down = !sb.held_down;
                send_item(CMD_KEY, key, down);
            end
        end
        drain();
    endtask

    // Stimulus
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: no slot in use, nothing matches, no timer to tick
        send_item(CMD_KEY, 16'h0000, 1'b1);
        send_item(CMD_TICK, 16'hFFFF, 1'b0);
        drain();

        // Two slots in use, long press after three ticks
        slot_cfg = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h7FFE, 16'h00FF};
        load_settings(32'd3, 3'd2);
        send_item(CMD_KEY, 16'hFFFF, 1'b1);   // press
        send_item(CMD_KEY, 16'hFFFF, 1'b1);   // matched, no edge
        send_item(CMD_KEY, 16'h0000, 1'b1);   // other key becomes the last key seen
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_TICK, 16'h0000, 1'b0);  // long press names the later key
        send_item(CMD_TICK, 16'h0000, 1'b0);  // timer already stopped
        send_item(CMD_KEY, 16'hFFFF, 1'b0);   // release after long press
        send_item(CMD_KEY, 16'hFFFF, 1'b0);   // release without edge
        send_item(CMD_KEY, 16'h1234, 1'b1);   // slot beyond key count
        send_item(CMD_KEY, 16'h0000, 1'b1);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_KEY, 16'h0000, 1'b0);   // short press and release
        drain();

        // Key count above the slot total, zero ticks, duplicate slots
        slot_cfg = '{16'h0000, 16'hFFFF, 16'h1234, 16'h5555, 16'h5555, 16'hAAAA};
        load_settings(32'd0, 3'd7);
        send_item(CMD_KEY, 16'h5555, 1'b1);
        send_item(CMD_TICK, 16'h5555, 1'b1);
        send_item(CMD_KEY, 16'hAAAA, 1'b0);
        drain();

        // Largest tick count: no long press within a few ticks
        load_settings(32'hFFFF_FFFF, 3'd6);
        send_item(CMD_KEY, 16'hAAAA, 1'b1);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_KEY, 16'h1234, 1'b0);
        drain();

        // Random phases over several settings
        random_phase(TICK_W'($urandom_range(0, 6)), 3'd1);
        random_phase(TICK_W'($urandom_range(0, 6)), CNT_W'($urandom_range(2, 6)));
        random_phase(TICK_W'($urandom_range(0, 6)), CNT_W'($urandom_range(2, 6)));
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        random_phase(TICK_W'($urandom_range(0, 6)), CNT_W'($urandom_range(2, 6)));
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        random_phase(TICK_W'($urandom_range(7, 20)), CNT_W'($urandom_range(2, 6)));
        random_phase(TICK_W'($urandom_range(0, 6)), 3'd7);

        if (sb.fail_count == 0 && sb.pending_events.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/klp_pkg.sv
rtl/klp_if.sv
rtl/klp_cfg.sv
rtl/klp_core.sv
rtl/klp_outq.sv
rtl/key_long_press_event_generator.sv
verif/key_long_press_event_generator_tb.sv
